// ----- rtl/core/rans_byte_decoder_assert.svh -----
// Assertion helpers for the checker module of the decoder.
`ifndef RANS_BYTE_DECODER_ASSERT_SVH
`define RANS_BYTE_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RBD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rans_byte_decoder: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rans_byte_decoder: assertion failed");

`endif

// ----- rtl/core/rbd_pkg.sv -----
`timescale 1ns / 1ps

package rbd_pkg;

    // Fixed field widths
    localparam int MODE_W   = 2;
    localparam int FREQ_W   = 16;
    localparam int WORD_W   = 32;
    localparam int BYTE_W   = 8;
    localparam int PB_W     = 5;
    localparam int USED_W   = 2;
    localparam int STATUS_W = 2;

    // Running frequency sum, saturating
    localparam int SUM_W = 17;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic [PB_W-1:0] PROB_BITS_RESET = PB_W'(12);

    // Item modes
    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WORD   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DECODE = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_ZERO_FREQ = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD_TABLE = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NOT_READY = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_SLOT,
        S_ENTRY,
        S_NORM,
        S_EMIT
    } rbd_state_t;

endpackage

// ----- rtl/core/rbd_ram.sv -----
`timescale 1ns / 1ps

module rbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/rans_byte_decoder.sv -----
`timescale 1ns / 1ps

// Channel   Transfer on            Payload
// -------   --------------------   ---------------------------------------------
// in        in_valid & in_ready    mode, frequency, state_word, next_byte_a/_b
// out       out_valid & out_ready  symbol, bytes_used, status
// cfg       cfg_valid & cfg_ready  cfg_data (prob_bits), always ready
//
// Decode: slot table read, symbol entry read, multiply, then update and
// renormalise; the two memory reads are registered and chained.
// Frequency load: the symbol entry is written, then each of its slots in turn.
// Coder word load, mode 3 and rejected decodes give their result from idle.
// Reset clears control state only; the tables hold garbage until loaded.
// A result waits in the output register while the next item is taken; the
// core stalls only when a second result is ready before the first is taken.

module rans_byte_decoder #(
    parameter int SYMBOLS         = 256,
    parameter int MAX_PROB_BITS   = 16,
    parameter int RENORM_LOW_BITS = 23
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rbd_pkg::MODE_W-1:0]    mode,
    input  logic [rbd_pkg::FREQ_W-1:0]    frequency,
    input  logic [rbd_pkg::WORD_W-1:0]    state_word,
    input  logic [rbd_pkg::BYTE_W-1:0]    next_byte_a,
    input  logic [rbd_pkg::BYTE_W-1:0]    next_byte_b,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rbd_pkg::BYTE_W-1:0]    symbol,
    output logic [rbd_pkg::USED_W-1:0]    bytes_used,
    output logic [rbd_pkg::STATUS_W-1:0]  status,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rbd_pkg::PB_W-1:0]      cfg_data
);

    localparam int SYM_W  = $clog2(SYMBOLS);
    localparam int IDX_W  = $clog2(SYMBOLS + 1);
    localparam int SLOT_W = MAX_PROB_BITS;
    localparam int PTR_W  = MAX_PROB_BITS + 1;
    localparam int SUM_W  = rbd_pkg::SUM_W;
    localparam int WORD_W = rbd_pkg::WORD_W;
    localparam int FREQ_W = rbd_pkg::FREQ_W;
    localparam int ENT_W  = 2 * FREQ_W;

    localparam logic [IDX_W-1:0]  IDX_FULL   = IDX_W'(SYMBOLS);
    localparam logic [SUM_W:0]    SLOT_LIMIT = (SUM_W + 1)'(1) << MAX_PROB_BITS;
    localparam logic [WORD_W-1:0] RENORM_THR = WORD_W'(1) << RENORM_LOW_BITS;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    rbd_pkg::rbd_state_t state_reg, state_next;

    logic [rbd_pkg::PB_W-1:0] prob_bits_reg, prob_bits_next;
    logic [WORD_W-1:0]        coder_state_reg, coder_state_next;
    logic [IDX_W-1:0]         load_index_reg, load_index_next;
    logic [SUM_W-1:0]         running_sum_reg, running_sum_next;
    logic                     zero_seen_reg, zero_seen_next;
    logic                     word_loaded_reg, word_loaded_next;
    logic                     out_valid_reg, out_valid_next;

    // payload, no reset
    logic [PTR_W-1:0]              fill_ptr_reg, fill_ptr_next;
    logic [PTR_W-1:0]              fill_end_reg, fill_end_next;
    logic [SYM_W-1:0]              fill_sym_reg, fill_sym_next;
    logic [rbd_pkg::BYTE_W-1:0]    byte_a_reg, byte_a_next;
    logic [rbd_pkg::BYTE_W-1:0]    byte_b_reg, byte_b_next;
    logic [WORD_W-1:0]             xs_reg, xs_next;
    logic [WORD_W-1:0]             product_reg, product_next;
    logic [FREQ_W-1:0]             start_reg, start_next;
    logic [SYM_W-1:0]              dec_sym_reg, dec_sym_next;
    logic [SYM_W-1:0]              res_sym_reg, res_sym_next;
    logic [rbd_pkg::USED_W-1:0]    res_used_reg, res_used_next;
    logic [rbd_pkg::STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [SYM_W-1:0]              out_sym_reg, out_sym_next;
    logic [rbd_pkg::USED_W-1:0]    out_used_reg, out_used_next;
    logic [rbd_pkg::STATUS_W-1:0]  out_status_reg, out_status_next;

    // ------------------------------------------------------------------
    // Memories: slot -> symbol, and symbol -> {freq, start}
    // ------------------------------------------------------------------
    logic              slot_we;
    logic [SLOT_W-1:0] slot_waddr;
    logic [SLOT_W-1:0] slot_raddr;
    logic [SYM_W-1:0]  slot_rdata;

    logic              ent_we;
    logic [SYM_W-1:0]  ent_waddr;
    logic [ENT_W-1:0]  ent_wdata;
    logic [ENT_W-1:0]  ent_rdata;

    rbd_ram #(
        .WIDTH (SYM_W),
        .DEPTH (1 << SLOT_W)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (fill_sym_reg),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    rbd_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SYMBOLS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (slot_rdata),
        .rdata (ent_rdata)
    );

    // ------------------------------------------------------------------
    // Effective slot width and derived terms
    // ------------------------------------------------------------------
    logic [rbd_pkg::PB_W-1:0] eff_bits;
    logic [SUM_W-1:0]         sum_target;
    logic [SLOT_W-1:0]        slot_mask;
    logic [SLOT_W-1:0]        slot_cur;
    logic                     table_ok;

    always_comb
    begin
        if (prob_bits_reg == '0)
        begin
            eff_bits = rbd_pkg::PB_W'(1);
        end
        else if (prob_bits_reg > rbd_pkg::PB_W'(MAX_PROB_BITS))
        begin
            eff_bits = rbd_pkg::PB_W'(MAX_PROB_BITS);
        end
        else
        begin
            eff_bits = prob_bits_reg;
        end
    end

    assign sum_target = SUM_W'(1) << eff_bits;
    assign slot_mask  = ~({SLOT_W{1'b1}} << eff_bits);
    assign slot_cur   = coder_state_reg[SLOT_W-1:0] & slot_mask;
    assign slot_raddr = slot_cur;
    assign table_ok   = (load_index_reg == IDX_FULL) && !zero_seen_reg
                        && (running_sum_reg == sum_target);

    // ------------------------------------------------------------------
    // Frequency load arithmetic; a load after a full table starts afresh
    // ------------------------------------------------------------------
    logic [IDX_W-1:0] ld_index;
    logic [IDX_W-1:0] ld_index_inc;
    logic [SUM_W-1:0] ld_sum;
    logic             ld_zero_seen;
    logic [SUM_W:0]   ld_sum_wide;
    logic [SUM_W-1:0] ld_sum_new;
    logic [SUM_W:0]   ld_end;
    logic             ld_fill;
    logic [rbd_pkg::STATUS_W-1:0] ld_status;

    always_comb
    begin
        if (load_index_reg >= IDX_FULL)
        begin
            ld_index     = '0;
            ld_sum       = '0;
            ld_zero_seen = 1'b0;
        end
        else
        begin
            ld_index     = load_index_reg;
            ld_sum       = running_sum_reg;
            ld_zero_seen = zero_seen_reg;
        end
        ld_index_inc = ld_index + IDX_W'(1);
        ld_sum_wide  = {1'b0, ld_sum} + (SUM_W + 1)'(frequency);
        ld_sum_new   = ld_sum_wide[SUM_W] ? rbd_pkg::SUM_MAX : ld_sum_wide[SUM_W-1:0];
        ld_end       = (ld_sum_wide > SLOT_LIMIT) ? SLOT_LIMIT : ld_sum_wide;
        ld_fill      = ({1'b0, ld_sum} < ld_end);
        if (frequency == '0)
        begin
            ld_status = rbd_pkg::STAT_ZERO_FREQ;
        end
        else if ((ld_index_inc == IDX_FULL) && (ld_sum_new != sum_target))
        begin
            ld_status = rbd_pkg::STAT_BAD_TABLE;
        end
        else
        begin
            ld_status = rbd_pkg::STAT_OK;
        end
    end

    // ------------------------------------------------------------------
    // State update and renormalisation
    // ------------------------------------------------------------------
    logic [WORD_W-1:0] x_upd;
    logic [WORD_W-1:0] x_one;
    logic [WORD_W-1:0] x_two;
    logic [rbd_pkg::USED_W-1:0] norm_used;

    always_comb
    begin
        x_upd = product_reg + WORD_W'(slot_cur) - WORD_W'(start_reg);
        if (x_upd < RENORM_THR)
        begin
            x_one = {x_upd[WORD_W-rbd_pkg::BYTE_W-1:0], byte_a_reg};
            if (x_one < RENORM_THR)
            begin
                x_two     = {x_one[WORD_W-rbd_pkg::BYTE_W-1:0], byte_b_reg};
                norm_used = rbd_pkg::USED_W'(2);
            end
            else
            begin
                x_two     = x_one;
                norm_used = rbd_pkg::USED_W'(1);
            end
        end
        else
        begin
            x_one     = x_upd;
            x_two     = x_upd;
            norm_used = '0;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic                         out_free;
    logic                         fin;
    logic [SYM_W-1:0]             fin_sym;
    logic [rbd_pkg::USED_W-1:0]   fin_used;
    logic [rbd_pkg::STATUS_W-1:0] fin_status;
    logic                         accept;
    logic [PTR_W-1:0]             ptr_inc;

    assign out_free = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign ptr_inc  = fill_ptr_reg + PTR_W'(1);

    always_comb
    begin
        state_next       = state_reg;
        coder_state_next = coder_state_reg;
        load_index_next  = load_index_reg;
        running_sum_next = running_sum_reg;
        zero_seen_next   = zero_seen_reg;
        word_loaded_next = word_loaded_reg;
        fill_ptr_next    = fill_ptr_reg;
        fill_end_next    = fill_end_reg;
        fill_sym_next    = fill_sym_reg;
        byte_a_next      = byte_a_reg;
        byte_b_next      = byte_b_reg;
        xs_next          = xs_reg;
        product_next     = product_reg;
        start_next       = start_reg;
        dec_sym_next     = dec_sym_reg;
        res_sym_next     = res_sym_reg;
        res_used_next    = res_used_reg;
        res_status_next  = res_status_reg;

        slot_we    = 1'b0;
        slot_waddr = fill_ptr_reg[SLOT_W-1:0];
        ent_we     = 1'b0;
        ent_waddr  = ld_index[SYM_W-1:0];
        ent_wdata  = {frequency, ld_sum[FREQ_W-1:0]};

        fin        = 1'b0;
        fin_sym    = '0;
        fin_used   = '0;
        fin_status = rbd_pkg::STAT_OK;

        in_ready   = (state_reg == rbd_pkg::S_IDLE);

        case (state_reg)
            rbd_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        rbd_pkg::MODE_LOAD:
                        begin
                            ent_we           = 1'b1;
                            load_index_next  = ld_index_inc;
                            running_sum_next = ld_sum_new;
                            zero_seen_next   = ld_zero_seen || (frequency == '0);
                            if (ld_fill)
                            begin
                                fill_ptr_next   = ld_sum[PTR_W-1:0];
                                fill_end_next   = ld_end[PTR_W-1:0];
                                fill_sym_next   = ld_index[SYM_W-1:0];
                                res_sym_next    = '0;
                                res_used_next   = '0;
                                res_status_next = ld_status;
                                state_next      = rbd_pkg::S_FILL;
                            end
                            else
                            begin
                                fin        = 1'b1;
                                fin_status = ld_status;
                            end
                        end
                        rbd_pkg::MODE_WORD:
                        begin
                            coder_state_next = state_word;
                            word_loaded_next = 1'b1;
                            fin              = 1'b1;
                        end
                        rbd_pkg::MODE_DECODE:
                        begin
                            if (!table_ok)
                            begin
                                fin        = 1'b1;
                                fin_status = rbd_pkg::STAT_BAD_TABLE;
                            end
                            else if (!word_loaded_reg)
                            begin
                                fin        = 1'b1;
                                fin_status = rbd_pkg::STAT_NOT_READY;
                            end
                            else
                            begin
                                // slot table read is issued this cycle
                                byte_a_next = next_byte_a;
                                byte_b_next = next_byte_b;
                                state_next  = rbd_pkg::S_SLOT;
                            end
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            rbd_pkg::S_FILL:
            begin
                slot_we       = 1'b1;
                fill_ptr_next = ptr_inc;
                if (ptr_inc == fill_end_reg)
                begin
                    fin        = 1'b1;
                    fin_sym    = res_sym_reg;
                    fin_used   = res_used_reg;
                    fin_status = res_status_reg;
                end
            end
            rbd_pkg::S_SLOT:
            begin
                // symbol now on slot_rdata; entry read issued
                xs_next    = coder_state_reg >> eff_bits;
                state_next = rbd_pkg::S_ENTRY;
            end
            rbd_pkg::S_ENTRY:
            begin
                product_next = WORD_W'({{(WORD_W - FREQ_W){1'b0}}, ent_rdata[ENT_W-1:FREQ_W]}
                                       * xs_reg);
                start_next   = ent_rdata[FREQ_W-1:0];
                dec_sym_next = slot_rdata;
                state_next   = rbd_pkg::S_NORM;
            end
            rbd_pkg::S_NORM:
            begin
                coder_state_next = x_two;
                fin              = 1'b1;
                fin_sym          = dec_sym_reg;
                fin_used         = norm_used;
            end
            rbd_pkg::S_EMIT:
            begin
                fin        = 1'b1;
                fin_sym    = res_sym_reg;
                fin_used   = res_used_reg;
                fin_status = res_status_reg;
            end
            default:
            begin
                state_next = rbd_pkg::S_IDLE;
            end
        endcase

        // Result goes straight to the output register if it is free,
        // otherwise it is parked until the pending transfer completes.
        out_valid_next  = out_valid_reg && !out_ready;
        out_sym_next    = out_sym_reg;
        out_used_next   = out_used_reg;
        out_status_next = out_status_reg;
        if (fin)
        begin
            if (out_free)
            begin
                out_valid_next  = 1'b1;
                out_sym_next    = fin_sym;
                out_used_next   = fin_used;
                out_status_next = fin_status;
                state_next      = rbd_pkg::S_IDLE;
            end
            else
            begin
                res_sym_next    = fin_sym;
                res_used_next   = fin_used;
                res_status_next = fin_status;
                state_next      = rbd_pkg::S_EMIT;
            end
        end
    end

    // Configuration is taken in any cycle
    assign cfg_ready      = 1'b1;
    assign prob_bits_next = cfg_valid ? cfg_data : prob_bits_reg;

    // ------------------------------------------------------------------
    // Clocked state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= rbd_pkg::S_IDLE;
            prob_bits_reg   <= rbd_pkg::PROB_BITS_RESET;
            coder_state_reg <= '0;
            load_index_reg  <= '0;
            running_sum_reg <= '0;
            zero_seen_reg   <= 1'b0;
            word_loaded_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            prob_bits_reg   <= prob_bits_next;
            coder_state_reg <= coder_state_next;
            load_index_reg  <= load_index_next;
            running_sum_reg <= running_sum_next;
            zero_seen_reg   <= zero_seen_next;
            word_loaded_reg <= word_loaded_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fill_ptr_reg   <= fill_ptr_next;
        fill_end_reg   <= fill_end_next;
        fill_sym_reg   <= fill_sym_next;
        byte_a_reg     <= byte_a_next;
        byte_b_reg     <= byte_b_next;
        xs_reg         <= xs_next;
        product_reg    <= product_next;
        start_reg      <= start_next;
        dec_sym_reg    <= dec_sym_next;
        res_sym_reg    <= res_sym_next;
        res_used_reg   <= res_used_next;
        res_status_reg <= res_status_next;
        out_sym_reg    <= out_sym_next;
        out_used_reg   <= out_used_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid  = out_valid_reg;
    assign symbol     = rbd_pkg::BYTE_W'(out_sym_reg);
    assign bytes_used = out_used_reg;
    assign status     = out_status_reg;

endmodule

// ----- rtl/core/rbd_checker.sv -----
`timescale 1ns / 1ps
`include "rans_byte_decoder_assert.svh"

module rbd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [rbd_pkg::BYTE_W-1:0]    symbol,
    input logic [rbd_pkg::USED_W-1:0]    bytes_used,
    input logic [rbd_pkg::STATUS_W-1:0]  status
);

    // stalled result holds
    `RBD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable({symbol, bytes_used, status}))

    // at most two stream bytes per symbol
    `RBD_ASSERT_NOW(a_used_range, clk, rst_n, out_valid, bytes_used != 2'd3)

    // only a good decode carries a symbol or consumes bytes
    `RBD_ASSERT_NOW(a_fail_zero, clk, rst_n, out_valid && (status != rbd_pkg::STAT_OK), (symbol == '0) && (bytes_used == '0))

endmodule

bind rans_byte_decoder rbd_checker u_rbd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .symbol     (symbol),
    .bytes_used (bytes_used),
    .status     (status)
);
